// File: rtl/pvpw_pkg.sv
// Shared types, constants and helper functions of the planar velocity PD wrench core.
`default_nettype none

package pvpw_pkg;

    localparam int unsigned ADDR_W      = 5;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned DIV_NUM_W   = 48;
    localparam int unsigned DIV_DEN_W   = 32;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_NUM_W);
    localparam int unsigned SQRT_RAD_W  = 42;
    localparam int unsigned SQRT_ROOT_W = SQRT_RAD_W / 2;
    localparam int unsigned SQRT_CNT_W  = $clog2(SQRT_ROOT_W);
    localparam int unsigned MUL_W       = 24;
    localparam int unsigned PROD_W      = 2 * MUL_W;
    localparam int unsigned PC_W        = 6;

    localparam logic [1:0] ACT_CMD  = 2'd0;
    localparam logic [1:0] ACT_ODO  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [2:0] REG_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_LIN_P   = 3'd1;
    localparam logic [2:0] REG_LIN_D   = 3'd2;
    localparam logic [2:0] REG_ANG_P   = 3'd3;
    localparam logic [2:0] REG_ANG_D   = 3'd4;
    localparam logic [2:0] REG_F_LIM   = 3'd5;
    localparam logic [2:0] REG_T_LIM   = 3'd6;

    localparam logic [PC_W-1:0] PC_ODO  = 6'd0;
    localparam logic [PC_W-1:0] PC_TICK = 6'd8;

    localparam logic signed [15:0] COS_ONE  = 16'sd16384;
    localparam logic signed [47:0] PD_LIMIT = 48'sd1048575;

    typedef enum logic [5:0] {
        U_NOP, U_O_WW, U_O_ZZ, U_O_WZ, U_O_DIVC, U_O_COS, U_O_DIVS, U_O_SIN, U_END_ODO,
        U_T_AGE, U_T_CX, U_T_SY, U_T_SX, U_T_CY, U_T_ROT,
        U_T_PX, U_T_DX, U_T_FX, U_T_PY, U_T_DY, U_T_FY, U_T_PA, U_T_DA, U_T_TQ,
        U_T_SQX, U_T_SQY, U_T_LL, U_T_CMP, U_T_SQRT,
        U_T_MX, U_T_DIVX, U_T_AX, U_T_MY, U_T_DIVY, U_T_AY, U_END_TICK
    } t_uop;

    typedef struct packed {
        logic [23:0] timeout;
        logic [15:0] lin_p;
        logic [15:0] lin_d;
        logic [15:0] ang_p;
        logic [15:0] ang_d;
        logic [19:0] force_lim;
        logic [19:0] torque_lim;
    } t_cfg;

    typedef struct packed {
        t_uop uop;
        logic load_cmd;
        logic load_odo;
        logic load_tick;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic limited;
    } t_dp_stat;

    function automatic t_uop uop_at(input logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            6'd0:    u = U_O_WW;
            6'd1:    u = U_O_ZZ;
            6'd2:    u = U_O_WZ;
            6'd3:    u = U_O_DIVC;
            6'd4:    u = U_O_COS;
            6'd5:    u = U_O_DIVS;
            6'd6:    u = U_O_SIN;
            6'd7:    u = U_END_ODO;
            6'd8:    u = U_T_AGE;
            6'd9:    u = U_T_CX;
            6'd10:   u = U_T_SY;
            6'd11:   u = U_T_SX;
            6'd12:   u = U_T_CY;
            6'd13:   u = U_T_ROT;
            6'd14:   u = U_T_PX;
            6'd15:   u = U_T_DX;
            6'd16:   u = U_T_FX;
            6'd17:   u = U_T_PY;
            6'd18:   u = U_T_DY;
            6'd19:   u = U_T_FY;
            6'd20:   u = U_T_PA;
            6'd21:   u = U_T_DA;
            6'd22:   u = U_T_TQ;
            6'd23:   u = U_T_SQX;
            6'd24:   u = U_T_SQY;
            6'd25:   u = U_T_LL;
            6'd26:   u = U_T_CMP;
            6'd27:   u = U_T_SQRT;
            6'd28:   u = U_T_MX;
            6'd29:   u = U_T_DIVX;
            6'd30:   u = U_T_AX;
            6'd31:   u = U_T_MY;
            6'd32:   u = U_T_DIVY;
            6'd33:   u = U_T_AY;
            6'd34:   u = U_END_TICK;
            default: u = U_NOP;
        endcase
        return u;
    endfunction

    function automatic logic is_start(input t_uop u);
        return (u == U_O_DIVC) || (u == U_O_DIVS) || (u == U_T_SQRT) ||
               (u == U_T_DIVX) || (u == U_T_DIVY);
    endfunction

    function automatic logic [47:0] abs48(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    // Rounds to nearest with ties away from zero.
    function automatic logic signed [47:0] round_shift(input logic signed [47:0] v,
                                                       input int unsigned sh);
        logic [47:0] m;
        m = (abs48(v) + (48'd1 << (sh - 1))) >> sh;
        return v[47] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [20:0] sat21(input logic signed [47:0] v);
        logic signed [20:0] r;
        if (v > PD_LIMIT) begin
            r = 21'sd1048575;
        end else if (v < -PD_LIMIT) begin
            r = -21'sd1048575;
        end else begin
            r = v[20:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pvpw_div.sv
// Restoring divider producing one quotient bit per cycle.
`default_nettype none

module pvpw_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [pvpw_pkg::DIV_NUM_W-1:0] i_dividend,
    input  wire logic [pvpw_pkg::DIV_DEN_W-1:0] i_divisor,
    output logic                                o_busy,
    output logic [pvpw_pkg::DIV_NUM_W-1:0]      o_quotient
);
    import pvpw_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_dsr;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;
    logic [DIV_DEN_W-1:0] n_rem;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_dsr};
        n_rem  = ge ? DIV_DEN_W'(rem_sh - {1'b0, r_dsr}) : rem_sh[DIV_DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
            r_cnt <= DIV_CNT_W'(DIV_NUM_W - 1);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_NUM_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: rtl/pvpw_sqrt.sv
// Floor integer square root, one result bit per cycle.
`default_nettype none

module pvpw_sqrt (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [pvpw_pkg::SQRT_RAD_W-1:0]  i_radicand,
    output logic                                  o_busy,
    output logic [pvpw_pkg::SQRT_ROOT_W-1:0]      o_root
);
    import pvpw_pkg::*;

    logic                   r_busy;
    logic [SQRT_CNT_W-1:0]  r_cnt;
    logic [SQRT_RAD_W-1:0]  r_rad;
    logic [SQRT_ROOT_W:0]   r_rem;
    logic [SQRT_ROOT_W-1:0] r_root;
    logic [SQRT_ROOT_W+2:0] rem_sh;
    logic [SQRT_ROOT_W+2:0] trial;
    logic                   ge;

    always_comb begin
        rem_sh = {r_rem, r_rad[SQRT_RAD_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= SQRT_CNT_W'(SQRT_ROOT_W - 1);
        end else if (r_busy) begin
            r_rad  <= {r_rad[SQRT_RAD_W-3:0], 2'b00};
            r_rem  <= ge ? (SQRT_ROOT_W+1)'(rem_sh - trial) : rem_sh[SQRT_ROOT_W:0];
            r_root <= {r_root[SQRT_ROOT_W-2:0], ge};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

// File: rtl/pvpw_datapath.sv
// Datapath: stored state, shared multiplier, rounding, saturation and the iterative units.
`default_nettype none

module pvpw_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pvpw_pkg::t_dp_cmd  i_cmd,
    input  wire pvpw_pkg::t_cfg     i_cfg,
    input  wire logic [31:0]        i_stamp_us,
    input  wire logic signed [15:0] i_vel_x,
    input  wire logic signed [15:0] i_vel_y,
    input  wire logic signed [15:0] i_yaw_rate,
    input  wire logic signed [15:0] i_quat_z,
    input  wire logic signed [15:0] i_quat_w,
    output pvpw_pkg::t_dp_stat      o_stat,
    output logic signed [20:0]      o_force_x,
    output logic signed [20:0]      o_force_y,
    output logic signed [20:0]      o_torque_z,
    output logic                    o_command_expired,
    output logic                    o_force_limited
);
    import pvpw_pkg::*;

    logic signed [15:0] r_tgt_x, r_tgt_y, r_tgt_yaw;
    logic [31:0]        r_cmd_stamp;
    logic signed [15:0] r_cos, r_sin;
    logic signed [15:0] r_meas_x, r_meas_y, r_meas_yaw;
    logic signed [15:0] r_qz, r_qw;
    logic [31:0]        r_stamp;

    logic signed [PROD_W-1:0] r_m0, r_m1, r_m2, r_m3;
    logic [31:0]              r_den;
    logic                     r_neg;
    logic signed [17:0]       r_twx, r_twy;
    logic signed [20:0]       r_fx, r_fy, r_tq;
    logic                     r_expired;
    logic                     r_limited;
    logic [SQRT_RAD_W-1:0]    r_sq;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] product;
    logic signed [15:0]       tx_e, ty_e, tyaw_e;
    logic signed [18:0]       err_x, err_y;
    logic signed [16:0]       err_yaw;
    logic [31:0]              age;
    logic [41:0]              sq;
    logic signed [20:0]       tlim;
    logic [20:0]              abs_fx, abs_fy;
    logic                     div_start;
    logic [DIV_NUM_W-1:0]     dividend;
    logic [DIV_DEN_W-1:0]     divisor;
    logic                     div_busy;
    logic [DIV_NUM_W-1:0]     quo;
    logic                     sqrt_busy;
    logic [SQRT_ROOT_W-1:0]   root;

    always_comb begin
        tx_e    = r_expired ? 16'sd0 : r_tgt_x;
        ty_e    = r_expired ? 16'sd0 : r_tgt_y;
        tyaw_e  = r_expired ? 16'sd0 : r_tgt_yaw;
        err_x   = 19'(r_twx) - 19'(r_meas_x);
        err_y   = 19'(r_twy) - 19'(r_meas_y);
        err_yaw = 17'(tyaw_e) - 17'(r_meas_yaw);
        age     = r_stamp - r_cmd_stamp;
        sq      = r_m0[41:0] + r_m1[41:0];
        tlim    = $signed({1'b0, i_cfg.torque_lim});
        abs_fx  = r_fx[20] ? 21'(-r_fx) : 21'(r_fx);
        abs_fy  = r_fy[20] ? 21'(-r_fy) : 21'(r_fy);
    end

    // Operand selection for the one shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.uop)
            U_O_WW:  begin mul_a = MUL_W'(r_qw);  mul_b = MUL_W'(r_qw);  end
            U_O_ZZ:  begin mul_a = MUL_W'(r_qz);  mul_b = MUL_W'(r_qz);  end
            U_O_WZ:  begin mul_a = MUL_W'(r_qw);  mul_b = MUL_W'(r_qz);  end
            U_T_CX:  begin mul_a = MUL_W'(r_cos); mul_b = MUL_W'(tx_e);  end
            U_T_SY:  begin mul_a = MUL_W'(r_sin); mul_b = MUL_W'(ty_e);  end
            U_T_SX:  begin mul_a = MUL_W'(r_sin); mul_b = MUL_W'(tx_e);  end
            U_T_CY:  begin mul_a = MUL_W'(r_cos); mul_b = MUL_W'(ty_e);  end
            U_T_PX:  begin mul_a = $signed(MUL_W'(i_cfg.lin_p)); mul_b = MUL_W'(err_x); end
            U_T_DX:  begin mul_a = $signed(MUL_W'(i_cfg.lin_d)); mul_b = MUL_W'(r_meas_x); end
            U_T_PY:  begin mul_a = $signed(MUL_W'(i_cfg.lin_p)); mul_b = MUL_W'(err_y); end
            U_T_DY:  begin mul_a = $signed(MUL_W'(i_cfg.lin_d)); mul_b = MUL_W'(r_meas_y); end
            U_T_PA:  begin mul_a = $signed(MUL_W'(i_cfg.ang_p)); mul_b = MUL_W'(err_yaw); end
            U_T_DA:  begin
                mul_a = $signed(MUL_W'(i_cfg.ang_d));
                mul_b = MUL_W'(r_meas_yaw);
            end
            U_T_SQX: begin mul_a = MUL_W'(r_fx);  mul_b = MUL_W'(r_fx);  end
            U_T_SQY: begin mul_a = MUL_W'(r_fy);  mul_b = MUL_W'(r_fy);  end
            U_T_LL:  begin
                mul_a = $signed(MUL_W'(i_cfg.force_lim));
                mul_b = $signed(MUL_W'(i_cfg.force_lim));
            end
            U_T_MX:  begin
                mul_a = $signed(MUL_W'(abs_fx));
                mul_b = $signed(MUL_W'(i_cfg.force_lim));
            end
            U_T_MY:  begin
                mul_a = $signed(MUL_W'(abs_fy));
                mul_b = $signed(MUL_W'(i_cfg.force_lim));
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        product = mul_a * mul_b;
    end

    // Divider operands; the half divisor added in gives round-to-nearest for the yaw terms.
    always_comb begin
        div_start = 1'b0;
        dividend  = '0;
        divisor   = r_den;
        unique case (i_cmd.uop)
            U_O_DIVC: begin
                div_start = 1'b1;
                dividend  = (abs48(r_m3) << 14) + DIV_NUM_W'(r_den[31:1]);
            end
            U_O_DIVS: begin
                div_start = 1'b1;
                dividend  = (abs48(r_m2) << 15) + DIV_NUM_W'(r_den[31:1]);
            end
            U_T_DIVX, U_T_DIVY: begin
                div_start = 1'b1;
                dividend  = r_m0;
                divisor   = DIV_DEN_W'(root);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    pvpw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    pvpw_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.uop == U_T_SQRT),
        .i_radicand (r_sq),
        .o_busy     (sqrt_busy),
        .o_root     (root)
    );

    // Block state that the item sequence relies on from reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_x     <= '0;
            r_tgt_y     <= '0;
            r_tgt_yaw   <= '0;
            r_cmd_stamp <= '0;
            r_meas_x    <= '0;
            r_meas_y    <= '0;
            r_meas_yaw  <= '0;
            r_cos       <= COS_ONE;
            r_sin       <= '0;
        end else begin
            if (i_cmd.load_cmd) begin
                r_tgt_x     <= i_vel_x;
                r_tgt_y     <= i_vel_y;
                r_tgt_yaw   <= i_yaw_rate;
                r_cmd_stamp <= i_stamp_us;
            end
            if (i_cmd.load_odo) begin
                r_meas_x   <= i_vel_x;
                r_meas_y   <= i_vel_y;
                r_meas_yaw <= i_yaw_rate;
            end
            if (i_cmd.uop == U_O_COS) begin
                r_cos <= (r_den == '0) ? COS_ONE : (r_neg ? 16'(-quo[15:0]) : quo[15:0]);
            end
            if (i_cmd.uop == U_O_SIN) begin
                r_sin <= (r_den == '0) ? 16'sd0 : (r_neg ? 16'(-quo[15:0]) : quo[15:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_odo) begin
            r_qz <= i_quat_z;
            r_qw <= i_quat_w;
        end
        if (i_cmd.load_tick) begin
            r_stamp <= i_stamp_us;
        end
        unique case (i_cmd.uop)
            U_O_WW, U_T_CX, U_T_PX, U_T_PY, U_T_PA, U_T_MX, U_T_MY: r_m0 <= product;
            U_O_ZZ, U_T_SY, U_T_DX, U_T_DY, U_T_DA, U_T_SQY:        r_m1 <= product;
            U_T_SX, U_T_LL:                                         r_m2 <= product;
            U_T_CY:                                                 r_m3 <= product;
            U_O_WZ: begin
                r_m2  <= product;
                r_m3  <= r_m0 - r_m1;
                r_den <= r_m0[31:0] + r_m1[31:0];
            end
            U_O_DIVC: r_neg <= r_m3[PROD_W-1];
            U_O_DIVS: r_neg <= r_m2[PROD_W-1];
            U_T_AGE:  r_expired <= age > {8'd0, i_cfg.timeout};
            U_T_ROT: begin
                r_twx <= 18'(round_shift(r_m0 - r_m1, 14));
                r_twy <= 18'(round_shift(r_m2 + r_m3, 14));
            end
            U_T_FX: r_fx <= sat21(round_shift(r_m0 - r_m1, 6));
            U_T_FY: r_fy <= sat21(round_shift(r_m0 - r_m1, 6));
            U_T_TQ: r_tq <= sat21(round_shift(r_m0 - r_m1, 6));
            U_T_SQX: begin
                r_m0 <= product;
                if (r_tq > tlim) begin
                    r_tq <= tlim;
                end else if (r_tq < -tlim) begin
                    r_tq <= -tlim;
                end
            end
            U_T_CMP: begin
                r_sq      <= sq;
                r_limited <= sq > r_m2[41:0];
            end
            U_T_AX: r_fx <= r_fx[20] ? -$signed(quo[20:0]) : $signed(quo[20:0]);
            U_T_AY: r_fy <= r_fy[20] ? -$signed(quo[20:0]) : $signed(quo[20:0]);
            default: begin
            end
        endcase
    end

    assign o_stat.busy       = div_busy | sqrt_busy;
    assign o_stat.limited    = r_limited;
    assign o_force_x         = r_fx;
    assign o_force_y         = r_fy;
    assign o_torque_z        = r_tq;
    assign o_command_expired = r_expired;
    assign o_force_limited   = r_limited;

endmodule

`default_nettype wire

// File: rtl/pvpw_ctrl.sv
// Controller: item dispatch and the micro-step sequencer that drives the datapath.
`default_nettype none

module pvpw_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [1:0]         i_action,
    output logic                    o_stall,
    output logic                    o_valid,
    input  wire logic               i_stall,
    input  wire pvpw_pkg::t_dp_stat i_stat,
    output pvpw_pkg::t_dp_cmd       o_cmd
);
    import pvpw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_odo_seen, n_odo_seen;
    t_uop            uop;

    always_comb begin
        uop        = uop_at(r_pc);
        n_state    = r_state;
        n_pc       = r_pc;
        n_odo_seen = r_odo_seen;
        o_cmd.uop       = U_NOP;
        o_cmd.load_cmd  = 1'b0;
        o_cmd.load_odo  = 1'b0;
        o_cmd.load_tick = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_action)
                        ACT_CMD: o_cmd.load_cmd = 1'b1;
                        ACT_ODO: begin
                            o_cmd.load_odo = 1'b1;
                            n_odo_seen     = 1'b1;
                            n_pc           = PC_ODO;
                            n_state        = S_RUN;
                        end
                        ACT_TICK: begin
                            o_cmd.load_tick = 1'b1;
                            if (r_odo_seen) begin
                                n_pc    = PC_TICK;
                                n_state = S_RUN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                priority if (uop == U_END_ODO) begin
                    n_state = S_IDLE;
                end else if (uop == U_END_TICK) begin
                    n_state = S_OUT;
                end else if (uop == U_T_SQRT && !i_stat.limited) begin
                    // Within the limit the vector goes out unscaled.
                    n_state = S_OUT;
                end else begin
                    o_cmd.uop = uop;
                    n_pc      = r_pc + 1'b1;
                    if (is_start(uop)) begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (!i_stat.busy) begin
                    n_state = S_RUN;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pc       <= '0;
            r_odo_seen <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pc       <= n_pc;
            r_odo_seen <= n_odo_seen;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

endmodule

`default_nettype wire

// File: rtl/planar_velocity_pd_wrench_core.sv
// Top level of the planar velocity PD wrench core: register file, controller and datapath.
`default_nettype none

// Command items are taken without stalling the input. An odometry item runs two passes of
// the shared bit-serial divider that forms the yaw cosine and sine. A control tick skips
// the square root and the divider when the force stays within its limit; when it is
// scaled, it runs the square root and then two more divider passes. One transaction is
// in work at a time; the input is stalled until its result, if any, has been taken.
// Registers sit at byte addresses 4*i and must be written while idle.

module planar_velocity_pd_wrench_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_action,
    input  wire logic [31:0]          i_stamp_us,
    input  wire logic signed [15:0]   i_vel_x,
    input  wire logic signed [15:0]   i_vel_y,
    input  wire logic signed [15:0]   i_yaw_rate,
    input  wire logic signed [15:0]   i_quat_z,
    input  wire logic signed [15:0]   i_quat_w,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [20:0]        o_force_x,
    output logic signed [20:0]        o_force_y,
    output logic signed [20:0]        o_torque_z,
    output logic                      o_command_expired,
    output logic                      o_force_limited
);
    import pvpw_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;
    t_dp_cmd    cmd;
    t_dp_stat   stat;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout    <= 24'd500000;
            r_cfg.lin_p      <= 16'd9600;
            r_cfg.lin_d      <= 16'd1920;
            r_cfg.ang_p      <= 16'd1280;
            r_cfg.ang_d      <= 16'd320;
            r_cfg.force_lim  <= 20'd51200;
            r_cfg.torque_lim <= 20'd7680;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TIMEOUT: r_cfg.timeout    <= pwdata[23:0];
                REG_LIN_P:   r_cfg.lin_p      <= pwdata[15:0];
                REG_LIN_D:   r_cfg.lin_d      <= pwdata[15:0];
                REG_ANG_P:   r_cfg.ang_p      <= pwdata[15:0];
                REG_ANG_D:   r_cfg.ang_d      <= pwdata[15:0];
                REG_F_LIM:   r_cfg.force_lim  <= pwdata[19:0];
                REG_T_LIM:   r_cfg.torque_lim <= pwdata[19:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TIMEOUT: prdata = DATA_W'(r_cfg.timeout);
            REG_LIN_P:   prdata = DATA_W'(r_cfg.lin_p);
            REG_LIN_D:   prdata = DATA_W'(r_cfg.lin_d);
            REG_ANG_P:   prdata = DATA_W'(r_cfg.ang_p);
            REG_ANG_D:   prdata = DATA_W'(r_cfg.ang_d);
            REG_F_LIM:   prdata = DATA_W'(r_cfg.force_lim);
            REG_T_LIM:   prdata = DATA_W'(r_cfg.torque_lim);
            default:     prdata = '0;
        endcase
    end

    pvpw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    pvpw_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg             (r_cfg),
        .i_stamp_us        (i_stamp_us),
        .i_vel_x           (i_vel_x),
        .i_vel_y           (i_vel_y),
        .i_yaw_rate        (i_yaw_rate),
        .i_quat_z          (i_quat_z),
        .i_quat_w          (i_quat_w),
        .o_stat            (stat),
        .o_force_x         (o_force_x),
        .o_force_y         (o_force_y),
        .o_torque_z        (o_torque_z),
        .o_command_expired (o_command_expired),
        .o_force_limited   (o_force_limited)
    );

endmodule

`default_nettype wire

// File: tb/tb_planar_velocity_pd_wrench_core.sv
// Self-checking testbench for the planar velocity PD wrench core.
`timescale 1ns / 1ps

module tb_planar_velocity_pd_wrench_core;
    import pvpw_pkg::*;

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        logic signed [20:0] fx;
        logic signed [20:0] fy;
        logic signed [20:0] tq;
        logic               expired;
        logic               limited;
    } t_wrench;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_action = ACT_UNKNOWN;
    logic [31:0] i_stamp_us = '0;
    logic signed [15:0] i_vel_x = '0, i_vel_y = '0, i_yaw_rate = '0;
    logic signed [15:0] i_quat_z = '0, i_quat_w = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [20:0] o_force_x, o_force_y, o_torque_z;
    logic o_command_expired, o_force_limited;

    planar_velocity_pd_wrench_core i_dut (.*);

    always #6 i_clk = ~i_clk;

    // Controller state as the core should hold it.
    longint cfg_timeout = 500000, cfg_lin_p = 9600, cfg_lin_d = 1920;
    longint cfg_ang_p = 1280, cfg_ang_d = 320, cfg_f_lim = 51200, cfg_t_lim = 7680;
    longint tgt_x, tgt_y, tgt_yaw, meas_x, meas_y, meas_yaw, yaw_cos = 16384, yaw_sin;
    logic [31:0] cmd_stamp = '0;
    bit odo_seen;

    t_wrench expected_wrench[$];
    int mismatches = 0;
    int cycles = 0;
    int burst_left = 0;
    longint now_us = 0;

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint round_sh(longint v, int sh);
        longint m;
        m = (mag(v) + (64'sd1 <<< (sh - 1))) >>> sh;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint round_quot(longint num, longint den);
        longint m;
        m = (mag(num) + den / 2) / den;
        return num < 0 ? -m : m;
    endfunction

    function automatic longint clamp(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint floor_sqrt(longint x);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint pd_force(longint kp, longint err, longint kd, longint meas);
        return clamp(round_sh(kp * err - kd * meas, 6), 1048575);
    endfunction

    // Updates the controller state for one transaction and queues any wrench it produces.
    task automatic predict_wrench(logic [1:0] act, logic [31:0] st, logic signed [15:0] vx,
                                  logic signed [15:0] vy, logic signed [15:0] vr,
                                  logic signed [15:0] qz, logic signed [15:0] qw);
        longint z, w, den, tx, ty, tr, twx, twy, fx, fy, tq, sq, m;
        logic [31:0] age;
        t_wrench r;
        z = qz;
        w = qw;
        if (act == ACT_CMD) begin
            tgt_x = vx; tgt_y = vy; tgt_yaw = vr; cmd_stamp = st;
        end else if (act == ACT_ODO) begin
            meas_x = vx; meas_y = vy; meas_yaw = vr;
            den = w * w + z * z;
            if (den == 0) begin
                yaw_cos = 16384; yaw_sin = 0;
            end else begin
                yaw_cos = round_quot((w * w - z * z) * 16384, den);
                yaw_sin = round_quot(2 * w * z * 16384, den);
            end
            odo_seen = 1'b1;
        end else if (act == ACT_TICK && odo_seen) begin
            age = st - cmd_stamp;
            r.expired = longint'(age) > cfg_timeout;
            tx = r.expired ? 0 : tgt_x;
            ty = r.expired ? 0 : tgt_y;
            tr = r.expired ? 0 : tgt_yaw;
            twx = round_sh(yaw_cos * tx - yaw_sin * ty, 14);
            twy = round_sh(yaw_sin * tx + yaw_cos * ty, 14);
            fx = pd_force(cfg_lin_p, twx - meas_x, cfg_lin_d, meas_x);
            fy = pd_force(cfg_lin_p, twy - meas_y, cfg_lin_d, meas_y);
            tq = pd_force(cfg_ang_p, tr - meas_yaw, cfg_ang_d, meas_yaw);
            sq = fx * fx + fy * fy;
            r.limited = sq > cfg_f_lim * cfg_f_lim;
            if (r.limited) begin
                m = floor_sqrt(sq);
                fx = fx < 0 ? -(mag(fx) * cfg_f_lim / m) : fx * cfg_f_lim / m;
                fy = fy < 0 ? -(mag(fy) * cfg_f_lim / m) : fy * cfg_f_lim / m;
            end
            tq = clamp(tq, cfg_t_lim);
            r.fx = fx[20:0];
            r.fy = fy[20:0];
            r.tq = tq[20:0];
            expected_wrench.push_back(r);
        end
    endtask

    // Drives one transaction, with a random gap at the start of each burst.
    task automatic send_item(logic [1:0] act, logic [31:0] st, logic signed [15:0] vx,
                             logic signed [15:0] vy, logic signed [15:0] vr,
                             logic signed [15:0] qz, logic signed [15:0] qw);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_action <= act; i_stamp_us <= st;
        i_vel_x <= vx; i_vel_y <= vy; i_yaw_rate <= vr;
        i_quat_z <= qz; i_quat_w <= qw;
        do @(posedge i_clk); while (o_stall);
        predict_wrench(act, st, vx, vy, vr, qz, qw);
    endtask

    // Lets every queued wrench come out and the core fall idle.
    task automatic drain_to_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (expected_wrench.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val[31:0];
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_TIMEOUT: cfg_timeout = val;
            REG_LIN_P:   cfg_lin_p = val;
            REG_LIN_D:   cfg_lin_d = val;
            REG_ANG_P:   cfg_ang_p = val;
            REG_ANG_D:   cfg_ang_d = val;
            REG_F_LIM:   cfg_f_lim = val;
            REG_T_LIM:   cfg_t_lim = val;
            default: ;
        endcase
    endtask

    task automatic set_gains(longint to, longint lp, longint ld, longint ap, longint ad,
                             longint fl, longint tl);
        drain_to_idle();
        write_reg(REG_TIMEOUT, to);
        write_reg(REG_LIN_P, lp);
        write_reg(REG_LIN_D, ld);
        write_reg(REG_ANG_P, ap);
        write_reg(REG_ANG_D, ad);
        write_reg(REG_F_LIM, fl);
        write_reg(REG_T_LIM, tl);
    endtask

    function automatic logic signed [15:0] rand_vel();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 4096)) - 16'sd2048;
    endfunction

    function automatic logic signed [15:0] rand_quat();
        return 16'($urandom_range(0, 32768)) - 16'sd16384;
    endfunction

    task automatic test_directed_cases();
        send_item(ACT_TICK, 32'd0, 16'sd100, 16'sd100, 16'sd100, 0, 0);
        send_item(ACT_UNKNOWN, 32'hFFFF_FFFF, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_item(ACT_ODO, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_item(ACT_TICK, 32'd10, 0, 0, 0, 0, 0);
        send_item(ACT_CMD, 32'd100, 16'sd32767, -16'sd32768, 16'sd32767, 0, 0);
        send_item(ACT_ODO, 32'd100, -16'sd32768, 16'sd32767, -16'sd32768,
                  16'sd0, 16'sd16384);
        send_item(ACT_TICK, 32'd500100, 0, 0, 0, 0, 0);
        send_item(ACT_TICK, 32'd500101, 0, 0, 0, 0, 0);
        send_item(ACT_ODO, 32'd200, 16'sd256, -16'sd256, 16'sd128,
                  16'sd16384, -16'sd16384);
        send_item(ACT_CMD, 32'hFFFF_FFF0, 16'sd512, 16'sd256, -16'sd300, 0, 0);
        send_item(ACT_TICK, 32'h0000_0010, 0, 0, 0, 0, 0);
        send_item(ACT_UNKNOWN, 32'd5, 16'sd1000, 16'sd1000, 16'sd1000, 16'sd1, 16'sd1);
        send_item(ACT_TICK, 32'h0000_0020, 0, 0, 0, 0, 0);
        send_item(ACT_ODO, 32'd300, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0);
        send_item(ACT_TICK, 32'h0000_0030, 0, 0, 0, 0, 0);
        send_item(ACT_CMD, 32'd0, 16'sd0, 16'sd0, 16'sd0, 0, 0);
        send_item(ACT_TICK, 32'd0, 0, 0, 0, 0, 0);
    endtask

    // Mostly command/odometry/tick traffic around a running clock, with some stray stamps.
    task automatic test_random_traffic(int n_items);
        int pick;
        logic [31:0] st;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            now_us += $urandom_range(0, 20000);
            if (pick < 28) begin
                send_item(ACT_CMD, 32'(now_us), rand_vel(), rand_vel(), rand_vel(),
                          rand_quat(), rand_quat());
            end else if (pick < 55) begin
                send_item(ACT_ODO, 32'($urandom), rand_vel(), rand_vel(), rand_vel(),
                          rand_quat(), rand_quat());
            end else if (pick < 95) begin
                st = ($urandom_range(0, 9) == 0) ? $urandom
                                                 : 32'(now_us + $urandom_range(0, 600000));
                send_item(ACT_TICK, st, rand_vel(), rand_vel(), rand_vel(),
                          rand_quat(), rand_quat());
            end else begin
                send_item(ACT_UNKNOWN, $urandom, rand_vel(), rand_vel(), rand_vel(),
                          rand_quat(), rand_quat());
            end
        end
    endtask

    task automatic test_gain_settings();
        set_gains(500000, 9600, 1920, 1280, 320, 51200, 7680);
        test_random_traffic(330);
        set_gains(10000000, 65535, 65535, 65535, 65535, 1048575, 1048575);
        test_random_traffic(330);
        set_gains(0, 0, 0, 0, 0, 0, 0);
        test_random_traffic(200);
        set_gains($urandom_range(0, 10000000), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 1048575),
                  $urandom_range(0, 1048575));
        test_random_traffic(440);
        set_gains($urandom_range(0, 400000), $urandom_range(0, 20000),
                  $urandom_range(0, 4000), $urandom_range(0, 4000),
                  $urandom_range(0, 1000), $urandom_range(0, 4096),
                  $urandom_range(0, 4096));
        test_random_traffic(440);
    endtask

    // The receiver switches between free flow, random stalls and a fixed stall rhythm.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 9) < 4);
            default: i_stall <= (cycles % 7) < 3;
        endcase
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_wrench e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_wrench.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected wrench transaction");
            end else begin
                e = expected_wrench.pop_front();
                if (o_force_x !== e.fx || o_force_y !== e.fy || o_torque_z !== e.tq ||
                    o_command_expired !== e.expired || o_force_limited !== e.limited) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("wrench mismatch: exp %0d %0d %0d %b %b got %0d %0d %0d %b %b",
                                 e.fx, e.fy, e.tq, e.expired, e.limited, o_force_x,
                                 o_force_y, o_torque_z, o_command_expired, o_force_limited);
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_gain_settings();
        drain_to_idle();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/pvpw_pkg.sv
rtl/pvpw_div.sv
rtl/pvpw_sqrt.sv
rtl/pvpw_datapath.sv
rtl/pvpw_ctrl.sv
rtl/planar_velocity_pd_wrench_core.sv
tb/tb_planar_velocity_pd_wrench_core.sv
